FILE: design/dgbs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dgbs_pkg
// Shared types, constants and glyph tables for the decimal glyph byte sequencer.
// ----------------------------------------------------------------------------
package dgbs_pkg;

    localparam int DGBS_FIFO_DEPTH = 4;

    localparam int DGBS_TEMP_W     = 10;
    localparam int DGBS_ROW_W      = 2;
    localparam int DGBS_RAW_W      = DGBS_TEMP_W + DGBS_ROW_W;
    localparam int DGBS_S_TDATA_W  = 16;
    localparam int DGBS_M_TDATA_W  = 8;

    // reciprocal multipliers for the constant divisions
    localparam logic [12:0] DIV100_MUL   = 13'd5243;
    localparam int          DIV100_SHIFT = 19;
    localparam logic [7:0]  DIV10_MUL    = 8'd205;
    localparam int          DIV10_SHIFT  = 11;
    localparam logic [9:0]  RADIX_HUNDRED = 10'd100;
    localparam logic [6:0]  RADIX_TEN     = 7'd10;

    localparam logic [7:0] CMD_COLUMN   = 8'h8f;
    localparam logic [7:0] POINT_COLUMN = 8'h80;
    localparam logic [7:0] ROW_CMD_0    = 8'h40;
    localparam logic [7:0] ROW_CMD_1    = 8'h42;
    localparam logic [7:0] ROW_CMD_2    = 8'h44;

    localparam logic [1:0] ROW_0    = 2'd0;
    localparam logic [1:0] ROW_1    = 2'd1;
    localparam logic [1:0] ROW_2    = 2'd2;
    localparam logic [1:0] ROW_NONE = 2'd3;

    localparam logic [3:0] DIGIT_ONE = 4'd1;
    localparam logic [3:0] DIGIT_MAX = 4'd9;

    localparam logic [2:0] GLYPH_LAST      = 3'd6;
    localparam logic [2:0] GLYPH_LAST_WIDE = 3'd7;

    typedef struct packed {
        logic [3:0] hundreds;
        logic [3:0] tens;
        logic [3:0] ones;
        logic [1:0] row;
    } dgbs_item_t;

    // eight columns per digit, column 0 in the low byte
    function automatic logic [63:0] glyph_row(input logic [3:0] digit);
        logic [63:0] r;
        case (digit)
            4'd0:    r = 64'h00007C8A92A27C00;
            4'd1:    r = 64'h008080FE84880000;
            4'd2:    r = 64'h00008C92A2C28400;
            4'd3:    r = 64'h00006C9292824400;
            4'd4:    r = 64'h000020FE24283000;
            4'd5:    r = 64'h0000629292925E00;
            4'd6:    r = 64'h0000649292927C00;
            4'd7:    r = 64'h0000060A12E20200;
            4'd8:    r = 64'h00006C9292926C00;
            4'd9:    r = 64'h00007C9292924C00;
            default: r = 64'h0;
        endcase
        return r;
    endfunction

    function automatic logic [7:0] glyph_col(input logic [3:0] digit, input logic [2:0] col);
        logic [63:0] r;
        r = glyph_row(digit);
        return r[{col, 3'b000} +: 8];
    endfunction

    function automatic logic [2:0] glyph_last(input logic [3:0] digit);
        return (digit == DIGIT_ONE) ? GLYPH_LAST_WIDE : GLYPH_LAST;
    endfunction

    function automatic logic [7:0] row_cmd(input logic [1:0] row);
        logic [7:0] c;
        case (row)
            ROW_0:   c = ROW_CMD_0;
            ROW_1:   c = ROW_CMD_1;
            ROW_2:   c = ROW_CMD_2;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

FILE: design/dgbs_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dgbs_fifo
// Input word queue in a synchronous memory; read data is registered and valid in the cycle after a pop.
// ----------------------------------------------------------------------------
module dgbs_fifo #(
    parameter int DEPTH = dgbs_pkg::DGBS_FIFO_DEPTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          push,
    input  logic [dgbs_pkg::DGBS_RAW_W-1:0] push_data,
    output logic                          full,
    input  logic                          pop,
    output logic                          not_empty,
    output logic                          rd_valid,
    output logic [dgbs_pkg::DGBS_RAW_W-1:0] rd_data
);
    import dgbs_pkg::*;

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    logic [DGBS_RAW_W-1:0] mem [0:DEPTH-1];
    logic [AW-1:0]         wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]         rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]         count_reg, count_next;
    logic                  rd_valid_reg;
    logic [DGBS_RAW_W-1:0] rd_data_reg;

    assign full      = (count_reg == CW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign rd_valid  = rd_valid_reg;
    assign rd_data   = rd_data_reg;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            count_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            wr_ptr_reg   <= wr_ptr_next;
            rd_ptr_reg   <= rd_ptr_next;
            count_reg    <= count_next;
            rd_valid_reg <= pop;
        end
    end

    // pop only with a stored entry, so the read slot never equals the write slot
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
        if (pop)
        begin
            rd_data_reg <= mem[rd_ptr_reg];
        end
    end

endmodule

FILE: design/dgbs_split.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dgbs_split
// Four stage pipeline splitting the value into hundreds, tens and ones.
// ----------------------------------------------------------------------------
module dgbs_split (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    input  logic [dgbs_pkg::DGBS_RAW_W-1:0] in_raw,
    output logic                            out_valid,
    output dgbs_pkg::dgbs_item_t            out_item
);
    import dgbs_pkg::*;

    logic [DGBS_TEMP_W-1:0] v_in;
    logic [22:0]            prod_a;
    logic [6:0]             rem_b;
    logic [14:0]            prod_c;
    logic [3:0]             ones_d;

    logic                   a_valid_reg, b_valid_reg, c_valid_reg, d_valid_reg;
    logic [DGBS_TEMP_W-1:0] v_a_reg;
    logic [3:0]             h_a_reg, h_b_reg, h_c_reg;
    logic [1:0]             row_a_reg, row_b_reg, row_c_reg;
    logic [6:0]             rem_b_reg, rem_c_reg;
    logic [3:0]             t_c_reg;
    dgbs_item_t             item_d_reg;

    assign v_in   = in_raw[DGBS_TEMP_W-1:0];
    assign prod_a = 23'(v_in) * 23'(DIV100_MUL);
    assign rem_b  = 7'(v_a_reg - 10'(h_a_reg) * RADIX_HUNDRED);
    assign prod_c = 15'(rem_b_reg) * 15'(DIV10_MUL);
    assign ones_d = 4'(rem_c_reg - 7'(t_c_reg) * RADIX_TEN);

    assign out_valid = d_valid_reg;
    assign out_item  = item_d_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        // hundreds by reciprocal, exact over the 10-bit range
        v_a_reg   <= v_in;
        h_a_reg   <= 4'(prod_a >> DIV100_SHIFT);
        row_a_reg <= in_raw[DGBS_RAW_W-1:DGBS_TEMP_W];

        rem_b_reg <= rem_b;
        h_b_reg   <= h_a_reg;
        row_b_reg <= row_a_reg;

        rem_c_reg <= rem_b_reg;
        t_c_reg   <= 4'(prod_c >> DIV10_SHIFT);
        h_c_reg   <= h_b_reg;
        row_c_reg <= row_b_reg;

        item_d_reg.hundreds <= h_c_reg;
        item_d_reg.tens     <= t_c_reg;
        item_d_reg.ones     <= ones_d;
        item_d_reg.row      <= row_c_reg;
    end

endmodule

FILE: design/dgbs_emit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dgbs_emit
// Byte sequencer with registered output: commands, glyph columns, point.
// ----------------------------------------------------------------------------
module dgbs_emit (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    input  dgbs_pkg::dgbs_item_t item,
    output logic                 item_take,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [7:0]           m_tdata,
    output logic                 m_tuser,
    output logic                 m_tlast
);
    import dgbs_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_CMD   = 7'b0000010,
        ST_ROW   = 7'b0000100,
        ST_HUND  = 7'b0001000,
        ST_TENS  = 7'b0010000,
        ST_POINT = 7'b0100000,
        ST_ONES  = 7'b1000000
    } emit_state_t;

    emit_state_t state_reg, state_next;
    logic [2:0]  col_reg, col_next;
    dgbs_item_t  item_reg, item_next;
    logic        m_tvalid_reg, m_tvalid_next;
    logic [7:0]  m_tdata_reg, m_tdata_next;
    logic        m_tuser_reg, m_tuser_next;
    logic        m_tlast_reg, m_tlast_next;

    logic        advance;
    logic [3:0]  cur_digit;
    logic [7:0]  cur_byte;
    logic        at_end;
    emit_state_t glyph_start;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;
    assign m_tlast  = m_tlast_reg;

    assign advance   = !m_tvalid_reg || m_tready;
    assign cur_digit = (state_reg == ST_HUND) ? item_reg.hundreds :
                       (state_reg == ST_TENS) ? item_reg.tens : item_reg.ones;
    assign cur_byte  = glyph_col(cur_digit, col_reg);
    assign at_end    = (col_reg == glyph_last(cur_digit));
    // hundreds digit of ten has no glyph
    assign glyph_start = (item_reg.hundreds > DIGIT_MAX) ? ST_TENS : ST_HUND;

    always_comb
    begin
        state_next    = state_reg;
        col_next      = col_reg;
        item_next     = item_reg;
        item_take     = 1'b0;
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        m_tuser_next  = m_tuser_reg;
        m_tlast_next  = m_tlast_reg;
        if (advance)
        begin
            m_tvalid_next = 1'b1;
            m_tlast_next  = 1'b0;
            m_tuser_next  = 1'b1;
            m_tdata_next  = cur_byte;
            case (state_reg)
                ST_IDLE:
                begin
                    m_tvalid_next = 1'b0;
                    if (item_valid)
                    begin
                        item_take  = 1'b1;
                        item_next  = item;
                        state_next = ST_CMD;
                    end
                end
                ST_CMD:
                begin
                    m_tdata_next = CMD_COLUMN;
                    m_tuser_next = 1'b0;
                    col_next     = '0;
                    state_next   = (item_reg.row != ROW_NONE) ? ST_ROW : glyph_start;
                end
                ST_ROW:
                begin
                    m_tdata_next = row_cmd(item_reg.row);
                    m_tuser_next = 1'b0;
                    col_next     = '0;
                    state_next   = glyph_start;
                end
                ST_HUND, ST_TENS:
                begin
                    if (at_end)
                    begin
                        col_next   = '0;
                        state_next = (state_reg == ST_HUND) ? ST_TENS : ST_POINT;
                    end
                    else
                    begin
                        col_next = col_reg + 1'b1;
                    end
                end
                ST_POINT:
                begin
                    m_tdata_next = POINT_COLUMN;
                    col_next     = '0;
                    state_next   = ST_ONES;
                end
                ST_ONES:
                begin
                    if (at_end)
                    begin
                        m_tlast_next = 1'b1;
                        col_next     = '0;
                        // chain straight into the next number when one is waiting
                        if (item_valid)
                        begin
                            item_take  = 1'b1;
                            item_next  = item;
                            state_next = ST_CMD;
                        end
                        else
                        begin
                            state_next = ST_IDLE;
                        end
                    end
                    else
                    begin
                        col_next = col_reg + 1'b1;
                    end
                end
                default:
                begin
                    m_tvalid_next = 1'b0;
                    state_next    = ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            col_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            col_reg      <= col_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg    <= item_next;
        m_tdata_reg <= m_tdata_next;
        m_tuser_reg <= m_tuser_next;
        m_tlast_reg <= m_tlast_next;
    end

endmodule

FILE: design/decimal_glyph_byte_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// decimal_glyph_byte_sequencer
// Turns a temperature in tenths and a row into a display command/glyph stream.
//
//   channel   dir   payload                                  end marker
//   s_axis    in    tdata: temp_tenths[9:0], row[11:10]      -
//   m_axis    out   tdata: byte_value[7:0], tuser: is_data   tlast
//
// each number yields 16 to 27 output words (23 to 27 below 1000), one per cycle
// while m_tready is high; the output word register sets the sustained rate. each
// number taken passes the queue read, four split stages, the item hold and the
// sequencer load before its first word appears. numbers queue in a small
// memory while the previous one streams out. reset clears all control state;
// m_tready low holds the output word and the whole sequence in place.
// ----------------------------------------------------------------------------
module decimal_glyph_byte_sequencer #(
    parameter int FIFO_DEPTH = dgbs_pkg::DGBS_FIFO_DEPTH
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [dgbs_pkg::DGBS_S_TDATA_W-1:0] s_tdata,   // temp_tenths[9:0], row[11:10]
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [dgbs_pkg::DGBS_M_TDATA_W-1:0] m_tdata,   // byte_value[7:0]
    output logic                                m_tuser,   // is_data[0]
    output logic                                m_tlast
);
    import dgbs_pkg::*;

    logic                  fifo_full;
    logic                  fifo_not_empty;
    logic                  fifo_pop;
    logic                  fifo_rd_valid;
    logic [DGBS_RAW_W-1:0] fifo_rd_data;
    logic                  split_valid;
    dgbs_item_t            split_item;
    logic                  item_take;

    logic                  pend_reg, pend_next;
    logic                  hold_valid_reg, hold_valid_next;
    dgbs_item_t            hold_reg;

    assign s_tready = !fifo_full;
    // one number in flight between the queue and the hold register
    assign fifo_pop = fifo_not_empty && !pend_reg && !hold_valid_reg;

    always_comb
    begin
        pend_next       = pend_reg;
        hold_valid_next = hold_valid_reg;
        if (fifo_pop)
        begin
            pend_next = 1'b1;
        end
        if (split_valid)
        begin
            pend_next       = 1'b0;
            hold_valid_next = 1'b1;
        end
        if (item_take)
        begin
            hold_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg       <= 1'b0;
            hold_valid_reg <= 1'b0;
        end
        else
        begin
            pend_reg       <= pend_next;
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (split_valid)
        begin
            hold_reg <= split_item;
        end
    end

    dgbs_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s_tvalid && s_tready),
        .push_data (s_tdata[DGBS_RAW_W-1:0]),
        .full      (fifo_full),
        .pop       (fifo_pop),
        .not_empty (fifo_not_empty),
        .rd_valid  (fifo_rd_valid),
        .rd_data   (fifo_rd_data)
    );

    dgbs_split u_split (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fifo_rd_valid),
        .in_raw    (fifo_rd_data),
        .out_valid (split_valid),
        .out_item  (split_item)
    );

    dgbs_emit u_emit (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (hold_valid_reg),
        .item       (hold_reg),
        .item_take  (item_take),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast)
    );

endmodule

FILE: design/dgbs_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dgbs_checker
// Port-level checks on the output word stream of the sequencer.
// ----------------------------------------------------------------------------
module dgbs_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tuser,
    input logic       m_tlast
);
    import dgbs_pkg::*;

    // stalled word holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                  && $stable(m_tlast))
        else $error("output word changed while stalled");

    // a sequence streams without gaps until its last word
    a_no_gap: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && !m_tlast |=> m_tvalid)
        else $error("gap inside a sequence");

    // command words are the column command or a row command
    a_cmd_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tuser |-> m_tdata == CMD_COLUMN || m_tdata == ROW_CMD_0
                                 || m_tdata == ROW_CMD_1 || m_tdata == ROW_CMD_2)
        else $error("unexpected command word");

    // the final word is always glyph data
    a_last_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast |-> m_tuser)
        else $error("last word flagged as command");

endmodule

bind decimal_glyph_byte_sequencer dgbs_checker u_dgbs_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
